// ----- rtl/cfsa_pkg.sv -----
// ----------------------------------------------------------------------------
// cfsa_pkg: shared types and constants for the CAN frame ASCII encoder
// Holds the microcode word layout, the control program and the hex digit table.
// ----------------------------------------------------------------------------
package cfsa_pkg;

  localparam logic [7:0] CHAR_CR       = 8'h0D;
  localparam logic [7:0] CHAR_EXT_DATA = 8'h54;  // 'T'
  localparam logic [7:0] CHAR_EXT_RTR  = 8'h52;  // 'R'
  localparam logic [7:0] CHAR_STD_DATA = 8'h74;  // 't'
  localparam logic [7:0] CHAR_STD_RTR  = 8'h72;  // 'r'

  localparam int unsigned MAX_BYTES = 8;

  localparam logic [7:0] HEX_DIGITS [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };

  typedef logic [2:0] step_t;

  localparam step_t STEP_TYPE = 3'd0;
  localparam step_t STEP_ID   = 3'd1;
  localparam step_t STEP_DLC  = 3'd2;
  localparam step_t STEP_DATA = 3'd3;
  localparam step_t STEP_CR   = 3'd4;

  // Character source selected by a control word
  typedef enum logic [2:0] {
    SRC_TYPE = 3'd0,
    SRC_ID   = 3'd1,
    SRC_DLC  = 3'd2,
    SRC_DATA = 3'd3,
    SRC_CR   = 3'd4
  } src_t;

  // Jump condition: when true the sequencer goes to target, else falls through
  typedef enum logic [2:0] {
    COND_NEXT      = 3'd0,
    COND_ID_MORE   = 3'd1,
    COND_NO_DATA   = 3'd2,
    COND_DATA_MORE = 3'd3,
    COND_END       = 3'd4
  } cond_t;

  typedef struct packed {
    src_t  src;
    logic  last;
    cond_t cond;
    step_t target;
  } ctrl_word_t;

  localparam ctrl_word_t PROGRAM [8] = '{
    '{src: SRC_TYPE, last: 1'b0, cond: COND_NEXT,      target: STEP_ID},
    '{src: SRC_ID,   last: 1'b0, cond: COND_ID_MORE,   target: STEP_ID},
    '{src: SRC_DLC,  last: 1'b0, cond: COND_NO_DATA,   target: STEP_CR},
    '{src: SRC_DATA, last: 1'b0, cond: COND_DATA_MORE, target: STEP_DATA},
    '{src: SRC_CR,   last: 1'b1, cond: COND_END,       target: STEP_TYPE},
    '{src: SRC_CR,   last: 1'b1, cond: COND_END,       target: STEP_TYPE},
    '{src: SRC_CR,   last: 1'b1, cond: COND_END,       target: STEP_TYPE},
    '{src: SRC_CR,   last: 1'b1, cond: COND_END,       target: STEP_TYPE}
  };

endpackage

// ----- rtl/cfsa_ifs.sv -----
// ----------------------------------------------------------------------------
// cfsa_ifs: channel interfaces of the CAN frame ASCII encoder
// Frame descriptor channel and character channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface cfsa_frame_if;
  logic        valid;
  logic        ready;
  logic        bus;
  logic        extended;
  logic        remote;
  logic [28:0] identifier;
  logic [3:0]  length_code;
  logic [63:0] payload;

  modport source (output valid, bus, extended, remote, identifier, length_code, payload,
                  input ready);
  modport sink   (input valid, bus, extended, remote, identifier, length_code, payload,
                  output ready);
endinterface

interface cfsa_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;

  modport source (output valid, character, last, input ready);
  modport sink   (input valid, character, last, output ready);
endinterface

// ----- rtl/can_frame_to_slcan_ascii_unit.sv -----
// ----------------------------------------------------------------------------
// can_frame_to_slcan_ascii_unit: CAN frame to serial-line ASCII text encoder
// Turns one frame descriptor into its ASCII text, one character per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   frame : sink of frame descriptors (bus, extended, remote, identifier,
//           length_code, payload). One transfer per frame.
//   text  : source of ASCII characters; the closing carriage return carries
//           last = 1.
// A frame transfer loads busy and step; the type letter is then loaded into the output register and shows on text.
// Throughput: one character per cycle while text is ready. A frame has 6 to 27
//   characters: letter, 8 or 3 identifier digits, DLC digit, two digits per
//   data byte (at most 8 bytes, none for remote frames), carriage return.
//   A short microcode program walks these steps; the step counter and the
//   identifier and data digit counters set the character count.
// frame.ready is high whenever no frame is in progress, so the next frame is
//   taken while the closing carriage return still sits in the output register.
// A stall on text holds the output register and freezes the sequencer.
// Reset clears the sequencer and drops any character waiting on text.
// ----------------------------------------------------------------------------
module can_frame_to_slcan_ascii_unit (
  input  logic                clk,
  input  logic                rst,
  cfsa_frame_if.sink          frame,
  cfsa_char_if.source         text
);

  // Sequencer state
  logic                 busy;
  cfsa_pkg::step_t      step;
  cfsa_pkg::ctrl_word_t cw;

  // Datapath registers, loaded when a frame transfers
  logic        remote;
  logic        extended;
  logic [3:0]  length_code;
  logic [31:0] id_shift;     // next identifier digit in the top nibble
  logic [2:0]  id_count;     // identifier digits left after the current one
  logic [63:0] data_shift;   // next data digit in the low nibble
  logic [3:0]  data_count;   // data digits left after the current one
  logic        no_data;

  // Output register
  logic       out_valid;
  logic [7:0] out_char;
  logic       out_last;

  logic       accept;
  logic       advance;
  logic       jump;
  logic [7:0] char_next;
  logic [3:0] byte_count;
  logic [63:0] swapped;
  logic [4:0] data_digits;

  assign accept  = frame.valid && frame.ready;
  assign advance = busy && (!out_valid || text.ready);
  assign cw      = cfsa_pkg::PROGRAM[step];

  assign frame.ready    = !busy;
  assign text.valid     = out_valid;
  assign text.character = out_char;
  assign text.last      = out_last;

  // Clamp the byte count; swap nibbles so each byte's high digit comes first
  assign byte_count  = (frame.length_code > 4'(cfsa_pkg::MAX_BYTES)) ?
                       4'(cfsa_pkg::MAX_BYTES) : frame.length_code;
  assign data_digits = {byte_count, 1'b0} - 5'd1;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      swapped[i*8 +: 4]     = frame.payload[i*8 + 4 +: 4];
      swapped[i*8 + 4 +: 4] = frame.payload[i*8 +: 4];
    end
  end

  // Character selected by the current control word
  always_comb begin
    case (cw.src)
      cfsa_pkg::SRC_TYPE: begin
        if (extended) char_next = remote ? cfsa_pkg::CHAR_EXT_RTR : cfsa_pkg::CHAR_EXT_DATA;
        else          char_next = remote ? cfsa_pkg::CHAR_STD_RTR : cfsa_pkg::CHAR_STD_DATA;
      end
      cfsa_pkg::SRC_ID:   char_next = cfsa_pkg::HEX_DIGITS[id_shift[31:28]];
      cfsa_pkg::SRC_DLC:  char_next = cfsa_pkg::HEX_DIGITS[length_code];
      cfsa_pkg::SRC_DATA: char_next = cfsa_pkg::HEX_DIGITS[data_shift[3:0]];
      default:            char_next = cfsa_pkg::CHAR_CR;
    endcase
  end

  // Jump decision
  always_comb begin
    case (cw.cond)
      cfsa_pkg::COND_ID_MORE:   jump = (id_count != 3'd0);
      cfsa_pkg::COND_NO_DATA:   jump = no_data;
      cfsa_pkg::COND_DATA_MORE: jump = (data_count != 4'd0);
      cfsa_pkg::COND_END:       jump = 1'b1;
      default:                  jump = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      step      <= cfsa_pkg::STEP_TYPE;
      out_valid <= 1'b0;
    end else begin
      // Load a new character, or drop the held one once it transfers
      if (advance) begin
        out_valid <= 1'b1;
      end else if (text.valid && text.ready) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        busy <= 1'b1;
        step <= cfsa_pkg::STEP_TYPE;
      end else if (advance) begin
        if (cw.cond == cfsa_pkg::COND_END) begin
          busy <= 1'b0;
        end
        step <= jump ? cw.target : step + 3'd1;
      end
    end
  end

  // Datapath and output payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      remote      <= frame.remote;
      extended    <= frame.extended;
      length_code <= frame.length_code;
      no_data     <= frame.remote || (frame.length_code == 4'd0);
      data_shift  <= swapped;
      data_count  <= data_digits[3:0];
      if (frame.extended) begin
        id_shift <= {3'b000, frame.identifier[28] | frame.bus, frame.identifier[27:0]};
        id_count <= 3'd7;
      end else begin
        id_shift <= {frame.identifier[11:0], 20'd0};
        id_count <= 3'd2;
      end
    end else if (advance) begin
      out_char <= char_next;
      out_last <= cw.last;
      if (cw.src == cfsa_pkg::SRC_ID) begin
        id_shift <= {id_shift[27:0], 4'd0};
        id_count <= id_count - 3'd1;
      end
      if (cw.src == cfsa_pkg::SRC_DATA) begin
        data_shift <= {4'd0, data_shift[63:4]};
        data_count <= data_count - 4'd1;
      end
    end
  end

  // Only the carriage return is marked last
  assert property (@(posedge clk) disable iff (rst)
    text.valid && text.last |-> text.character == cfsa_pkg::CHAR_CR)
    else $error("last set on a character other than carriage return");

  // A character that is not last always has more of its frame behind it
  assert property (@(posedge clk) disable iff (rst)
    text.valid && !text.last |-> busy)
    else $error("frame text ended without a carriage return");

  // A frame transfer starts the program at the type letter
  assert property (@(posedge clk) disable iff (rst)
    accept |=> busy && step == cfsa_pkg::STEP_TYPE)
    else $error("sequencer did not restart on a frame transfer");

  // Remote frames never reach the data digits
  assert property (@(posedge clk) disable iff (rst)
    busy && step == cfsa_pkg::STEP_DATA |-> !remote)
    else $error("data digits emitted for a remote frame");

endmodule
